@@ rtl/pmc_pkg.sv @@
// Package for the pairing mode controller: payload structs, mode encoding,
// register map and reset values. No dependencies.
package pmc_pkg;

    // Default width of the internal time arithmetic
    localparam int TIME_BITS_DEFAULT = 32;

    // Register reset values
    localparam logic [15:0] HOLD_TIME_RESET         = 16'd3000;
    localparam logic [23:0] DISCOVERY_TIMEOUT_RESET = 24'd30000;
    localparam logic [15:0] FLASH_INTERVAL_RESET    = 16'd500;

    // Register map: word index = paddr[3:2]
    localparam int PADDR_BITS = 4;
    typedef enum logic [1:0] {
        REG_HOLD_TIME         = 2'd0,
        REG_DISCOVERY_TIMEOUT = 2'd1,
        REG_FLASH_INTERVAL    = 2'd2
    } reg_index_t;

    // Controller modes
    typedef enum logic [1:0] {
        MODE_WAITING     = 2'd0,
        MODE_DISCOVERING = 2'd1,
        MODE_DISCOVERED  = 2'd2
    } mode_t;

    // One poll
    typedef struct packed {
        logic [31:0] now_ms;
        logic        button_down;
        logic        connect_event;
        logic        disconnect_event;
    } pmc_in_t;

    // One result
    typedef struct packed {
        logic [1:0] mode_now;
        logic       red_led;
        logic       blue_led;
        logic       start_advertising;
        logic       stop_advertising;
    } pmc_out_t;

endpackage

@@ rtl/pairing_mode_controller.sv @@
// Pairing mode controller top level: poll input register, mode step logic,
// result register and APB register file. Depends on pmc_pkg.
//
// Each poll transaction carries the millisecond time, the button level and
// connect/disconnect events; each produces exactly one result transaction
// with the mode, LED levels and advertising start/stop pulses. Throughput is
// one poll per clock cycle while the result channel is not stalled by
// m_ready. A poll is held in the input register; its result is presented
// from the result register after the step fires. A single pass of compare
// logic lies between those two registers.
// Registers: 0x0 hold_time_ms (16 bit), 0x4 discovery_timeout_ms (24 bit),
// 0x8 flash_interval_ms (16 bit); write them only while the block is idle.
// Time sums and compares wrap at TIME_BITS bits.
module pairing_mode_controller
    import pmc_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEFAULT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Poll channel
    input  logic                  s_valid,
    output logic                  s_ready,
    input  pmc_in_t               s_data,
    // Result channel
    output logic                  m_valid,
    input  logic                  m_ready,
    output pmc_out_t              m_data,
    // Configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_BITS-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    typedef logic [TIME_BITS-1:0] time_t;

    // Configuration registers
    logic [15:0] hold_time_reg;
    logic [23:0] discovery_timeout_reg;
    logic [15:0] flash_interval_reg;
    reg_index_t  reg_sel;
    logic        cfg_write;

    // Pipeline
    pmc_in_t  in_data_reg;
    logic     in_valid_reg;
    pmc_out_t out_data_reg;
    logic     out_valid_reg;
    pmc_out_t out_data_next;
    logic     advance;

    // Controller state
    mode_t mode_reg, mode_next;
    logic  button_was_down_reg, button_was_down_next;
    time_t hold_start_reg, hold_start_next;
    time_t discovery_start_reg, discovery_start_next;
    time_t discovered_time_reg, discovered_time_next;
    time_t next_flash_reg, next_flash_next;
    logic  connected_reg, connected_next;
    logic  red_reg, red_next;
    logic  blue_reg, blue_next;
    logic  stamp_due_reg, stamp_due_next;

    // Step-local values
    time_t now_t;
    logic  btn;
    logic  start_pulse;
    logic  stop_pulse;
    logic  hold_expired;
    logic  timeout_expired;
    logic  dwell_expired;

    // APB register file
    assign pready    = 1'b1;
    assign reg_sel   = reg_index_t'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_time_reg         <= HOLD_TIME_RESET;
            discovery_timeout_reg <= DISCOVERY_TIMEOUT_RESET;
            flash_interval_reg    <= FLASH_INTERVAL_RESET;
        end else if (cfg_write) begin
            unique case (reg_sel)
                REG_HOLD_TIME:         hold_time_reg         <= pwdata[15:0];
                REG_DISCOVERY_TIMEOUT: discovery_timeout_reg <= pwdata[23:0];
                REG_FLASH_INTERVAL:    flash_interval_reg    <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_HOLD_TIME:         prdata = {16'd0, hold_time_reg};
            REG_DISCOVERY_TIMEOUT: prdata = {8'd0, discovery_timeout_reg};
            REG_FLASH_INTERVAL:    prdata = {16'd0, flash_interval_reg};
            default:               prdata = 32'd0;
        endcase
    end

    // Handshake: the step fires when the input register holds a poll and
    // the result register is free or being drained this cycle
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= out_data_next;
        end
    end

    // Controller state registers, updated once per poll
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg            <= MODE_WAITING;
            button_was_down_reg <= 1'b0;
            hold_start_reg      <= '0;
            discovery_start_reg <= '0;
            discovered_time_reg <= '0;
            next_flash_reg      <= '0;
            connected_reg       <= 1'b0;
            red_reg             <= 1'b0;
            blue_reg            <= 1'b0;
            stamp_due_reg       <= 1'b0;
        end else if (advance) begin
            mode_reg            <= mode_next;
            button_was_down_reg <= button_was_down_next;
            hold_start_reg      <= hold_start_next;
            discovery_start_reg <= discovery_start_next;
            discovered_time_reg <= discovered_time_next;
            next_flash_reg      <= next_flash_next;
            connected_reg       <= connected_next;
            red_reg             <= red_next;
            blue_reg            <= blue_next;
            stamp_due_reg       <= stamp_due_next;
        end
    end

    // Time of this poll, wrapped to the internal width
    assign now_t = time_t'(in_data_reg.now_ms);
    assign btn   = in_data_reg.button_down;

    // Wrapped deadline compares
    assign hold_expired =
        now_t > time_t'(hold_start_reg + time_t'(hold_time_reg));
    assign timeout_expired =
        now_t > time_t'(discovery_start_reg + time_t'(discovery_timeout_reg));

    // Mode step: events first (connect, then disconnect), then the mode
    always_comb begin
        mode_next            = mode_reg;
        button_was_down_next = button_was_down_reg;
        hold_start_next      = hold_start_reg;
        discovery_start_next = discovery_start_reg;
        discovered_time_next = discovered_time_reg;
        next_flash_next      = next_flash_reg;
        connected_next       = connected_reg;
        red_next             = red_reg;
        blue_next            = blue_reg;
        stamp_due_next       = stamp_due_reg;
        start_pulse          = 1'b0;
        stop_pulse           = 1'b0;

        if (in_data_reg.connect_event) begin
            connected_next = 1'b1;
            blue_next      = 1'b1;
        end
        if (in_data_reg.disconnect_event) begin
            connected_next       = 1'b0;
            mode_next            = MODE_DISCOVERED;
            discovered_time_next = '0;
            stamp_due_next       = 1'b1;
        end

        // dwell compare uses the discovered time after a possible disconnect
        dwell_expired =
            now_t > time_t'(discovered_time_next + time_t'(hold_time_reg));

        unique case (mode_next)
            MODE_WAITING: begin
                if (button_was_down_reg && !btn) begin
                    button_was_down_next = 1'b0;
                end else if (!button_was_down_reg && btn) begin
                    hold_start_next      = now_t;
                    button_was_down_next = 1'b1;
                end else if (button_was_down_reg && btn && hold_expired) begin
                    mode_next            = MODE_DISCOVERING;
                    red_next             = 1'b0;
                    discovery_start_next = now_t;
                    hold_start_next      = now_t;
                    start_pulse          = 1'b1;
                end
            end
            MODE_DISCOVERING: begin
                if (!connected_next) begin
                    // blink blue
                    if (now_t >= next_flash_reg) begin
                        blue_next       = !blue_next;
                        next_flash_next = time_t'(now_t + time_t'(flash_interval_reg));
                    end
                    // long hold or timeout cancels discovery
                    if (button_was_down_reg && !btn) begin
                        button_was_down_next = 1'b0;
                    end else if (!button_was_down_reg && btn) begin
                        hold_start_next      = now_t;
                        button_was_down_next = 1'b1;
                    end else if ((button_was_down_reg && btn && hold_expired) ||
                                 timeout_expired) begin
                        mode_next       = MODE_WAITING;
                        red_next        = 1'b1;
                        blue_next       = 1'b0;
                        hold_start_next = now_t;
                        stop_pulse      = 1'b1;
                    end
                end
            end
            MODE_DISCOVERED: begin
                if (stamp_due_next) begin
                    stop_pulse           = 1'b1;
                    discovered_time_next = now_t;
                    stamp_due_next       = 1'b0;
                end else if (dwell_expired) begin
                    blue_next = 1'b0;
                    mode_next = MODE_WAITING;
                end
            end
            default: ;
        endcase

        out_data_next.mode_now          = mode_next;
        out_data_next.red_led           = red_next;
        out_data_next.blue_led          = blue_next;
        out_data_next.start_advertising = start_pulse;
        out_data_next.stop_advertising  = stop_pulse;
    end

endmodule
